@@ rtl/bqgf_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants and the rounding helper of the quadrilateral geometric factors unit.
package bqgf_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned REF_W   = 16;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned MINJ_W  = 17;
  localparam int unsigned RES_W   = 32;

  // Pipelined divider: 50-bit dividend, 33-bit divisor, 31 quotient bits
  // below the overflow check, one register stage per quotient bit.
  localparam int unsigned DIV_M_W   = 50;
  localparam int unsigned DIV_D_W   = 33;
  localparam int unsigned DIV_QBITS = 31;
  localparam int unsigned DIV_CMP_W = DIV_D_W + DIV_QBITS;
  localparam int unsigned DIV_LAT   = DIV_QBITS + 2;

  // Stages before the dividers, and after them up to the output register.
  localparam int unsigned PRE_STAGES  = 8;
  localparam int unsigned POST_STAGES = 4;
  localparam int unsigned PIPE_LEN    = PRE_STAGES + DIV_LAT + POST_STAGES;

  typedef logic signed [RES_W-1:0] q16_t;

  localparam q16_t SAT_MAX = 32'sh7fffffff;
  localparam q16_t SAT_MIN = 32'sh80000000;

  // Round a Q.32 value to Q16.16 (ties towards plus infinity) and clamp.
  function automatic q16_t round_sat16(input logic signed [80:0] v);
    logic signed [80:0] t;
    t = (v + 81'sd32768) >>> 16;
    if (t > 81'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (t < 81'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return q16_t'(t[RES_W-1:0]);
  endfunction

endpackage

@@ rtl/bqgf_div_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider giving a saturated, floor-rounded Q16.16 quotient.
module bqgf_div_pipe (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bqgf_pkg::DIV_M_W-1:0] m_in,
  input  logic [bqgf_pkg::DIV_D_W-1:0] d_in,
  input  logic                         neg_in,
  output bqgf_pkg::q16_t               q_out
);

  localparam int unsigned QB = bqgf_pkg::DIV_QBITS;
  localparam int unsigned DW = bqgf_pkg::DIV_D_W;

  logic [DW-1:0] rem_r  [QB+1];
  logic [QB-1:0] mlo_r  [QB+1];
  logic [QB-1:0] quo_r  [QB+1];
  logic [DW-1:0] d_r    [QB+1];
  logic          neg_r  [QB+1];
  logic          ovf_r  [QB+1];
  logic [DW:0]   trial  [QB];
  logic          take   [QB];
  bqgf_pkg::q16_t q_out_r;

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rem_r[k], mlo_r[k][QB-1]};
      take[k]  = (trial[k] >= {1'b0, d_r[k]});
    end
  end

  // The first stage checks whether the quotient reaches 2^31; if not, the
  // top dividend bits are already below the divisor and seed the remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(m_in[bqgf_pkg::DIV_M_W-1:QB]);
      mlo_r[0] <= m_in[QB-1:0];
      quo_r[0] <= '0;
      d_r[0]   <= d_in;
      neg_r[0] <= neg_in;
      ovf_r[0] <= (bqgf_pkg::DIV_CMP_W'(m_in) >= {d_in, {QB{1'b0}}});
      for (int k = 0; k < QB; k++) begin
        rem_r[k+1] <= take[k] ? DW'(trial[k] - {1'b0, d_r[k]}) : trial[k][DW-1:0];
        mlo_r[k+1] <= {mlo_r[k][QB-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][QB-2:0], take[k]};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
      // A negative dividend was complemented, so the floor quotient is the
      // complement of the magnitude quotient.
      if (ovf_r[QB]) begin
        q_out_r <= neg_r[QB] ? bqgf_pkg::SAT_MIN : bqgf_pkg::SAT_MAX;
      end else if (neg_r[QB]) begin
        q_out_r <= ~{1'b0, quo_r[QB]};
      end else begin
        q_out_r <= {1'b0, quo_r[QB]};
      end
    end
  end

  assign q_out = q_out_r;

endmodule

@@ rtl/bilinear_quad_geometric_factors_unit.sv @@
`timescale 1ns / 1ps
// Top level of the bilinear quadrilateral Jacobian and geometric factors unit.
//
// Usage: one item on the input channel carries the four vertices of a
// quadrilateral (signed Q16.16), a reference point r,s (signed Q2.14) and two
// quadrature weights (unsigned Q2.14). For each item exactly one item leaves
// on the output channel with the inverse metric, the determinant, the
// weighted determinant, its reciprocal and the three second-order factors.
// Both channels use valid and ready; an item moves when both are high.
// The configuration channel writes min_jacobian; it is always ready and
// should only be written while no item is in flight.
// From acceptance to the result being offered, eight stages form the
// entries, the determinant, the weighted determinant and the divider operands,
// 33 stages are the bit-per-stage dividers, and four stages form the
// second-order factors. One item is accepted in every cycle unless the output stalls.
// The whole pipeline advances together: while the output holds an item
// that the receiver does not take, every stage holds and in_ready is low,
// so nothing is lost or repeated. Reset clears the stage valid bits and sets
// min_jacobian to 1.
module bilinear_quad_geometric_factors_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bqgf_pkg::COORD_W-1:0] in_vert0_x,
  input  logic signed [bqgf_pkg::COORD_W-1:0] in_vert0_y,
  input  logic signed [bqgf_pkg::COORD_W-1:0] in_vert1_x,
  input  logic signed [bqgf_pkg::COORD_W-1:0] in_vert1_y,
  input  logic signed [bqgf_pkg::COORD_W-1:0] in_vert2_x,
  input  logic signed [bqgf_pkg::COORD_W-1:0] in_vert2_y,
  input  logic signed [bqgf_pkg::COORD_W-1:0] in_vert3_x,
  input  logic signed [bqgf_pkg::COORD_W-1:0] in_vert3_y,
  input  logic signed [bqgf_pkg::REF_W-1:0]   in_ref_r,
  input  logic signed [bqgf_pkg::REF_W-1:0]   in_ref_s,
  input  logic        [bqgf_pkg::WGT_W-1:0]   in_weight_r,
  input  logic        [bqgf_pkg::WGT_W-1:0]   in_weight_s,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bqgf_pkg::q16_t                      out_metric_rx,
  output bqgf_pkg::q16_t                      out_metric_ry,
  output bqgf_pkg::q16_t                      out_metric_sx,
  output bqgf_pkg::q16_t                      out_metric_sy,
  output bqgf_pkg::q16_t                      out_jacobian,
  output bqgf_pkg::q16_t                      out_weighted_jacobian,
  output bqgf_pkg::q16_t                      out_inverse_weighted,
  output bqgf_pkg::q16_t                      out_factor_rr,
  output bqgf_pkg::q16_t                      out_factor_rs,
  output bqgf_pkg::q16_t                      out_factor_ss,
  output logic                                out_bad_jacobian,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [bqgf_pkg::MINJ_W-1:0]  cfg_min_jacobian
);

  localparam int unsigned NL = bqgf_pkg::PIPE_LEN;
  localparam int unsigned DL = bqgf_pkg::DIV_LAT;
  localparam logic signed [17:0] ONE14 = 18'sd16384;

  typedef struct packed {
    bqgf_pkg::q16_t xr;
    bqgf_pkg::q16_t xs;
    bqgf_pkg::q16_t yr;
    bqgf_pkg::q16_t ys;
  } entry_t;

  typedef struct packed {
    bqgf_pkg::q16_t jac;
    bqgf_pkg::q16_t jw;
    logic           bad;
  } side_t;

  typedef struct packed {
    bqgf_pkg::q16_t rx;
    bqgf_pkg::q16_t ry;
    bqgf_pkg::q16_t sx;
    bqgf_pkg::q16_t sy;
    bqgf_pkg::q16_t inv;
  } metric_t;

  logic                       en;
  logic [NL-1:0]              vld_r;
  logic [bqgf_pkg::MINJ_W-1:0] min_jacobian_r;

  // Stage 1: vertex differences, coordinate factors and the weight product.
  logic signed [32:0] xa_r, xb_r, xc_r, xd_r, ya_r, yb_r, yc_r, yd_r;
  logic signed [17:0] cms_r, cps_r, cmr_r, cpr_r;
  logic [31:0]        w1_r;

  // Stage 2: the eight entry products.
  logic signed [50:0] pxa_r, pxb_r, pxc_r, pxd_r, pya_r, pyb_r, pyc_r, pyd_r;
  logic [31:0]        w2_r;

  // Stages 3 to 7.
  entry_t             e3_r, e4_r, e5_r, e6_r, e7_r;
  logic [31:0]        w3_r, w4_r, w5_r;
  logic signed [63:0] pja_r, pjb_r;
  bqgf_pkg::q16_t     jac_nxt;
  bqgf_pkg::q16_t     jac5_r, jac6_r, jac7_r;
  logic               bad5_r, bad6_r, bad7_r;
  logic [62:0]        pjw_r;
  logic [63:0]        jw_sum;
  bqgf_pkg::q16_t     jw7_r;

  // Stage 8: divider operands.
  logic [bqgf_pkg::DIV_M_W-1:0] div_m_r   [5];
  logic [bqgf_pkg::DIV_D_W-1:0] div_d_r   [5];
  logic                         div_neg_r [5];
  logic [bqgf_pkg::DIV_M_W:0]   prep      [4];
  logic signed [32:0]           num       [4];
  bqgf_pkg::q16_t               div_q     [5];
  side_t                        side_r    [DL+1];

  // Stages 42 to 45.
  metric_t            m42_r, m43_r, m44_r;
  side_t              s42_r, s43_r, s44_r;
  logic signed [63:0] prr_a_r, prr_b_r, prs_a_r, prs_b_r, pss_a_r, pss_b_r;
  logic signed [48:0] grr_r, grs_r, gss_r;
  logic signed [56:0] hrr_r, hrs_r, hss_r;
  logic [54:0]        lrr_r, lrs_r, lss_r;

  bqgf_pkg::q16_t out_rx_r, out_ry_r, out_sx_r, out_sy_r, out_jac_r, out_jw_r, out_inv_r;
  bqgf_pkg::q16_t out_rr_r, out_rs_r, out_ss_r;
  logic           out_bad_r;

  // The pipeline moves as one; it stalls only when the output item waits.
  assign en        = ~vld_r[NL-1] | out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r          <= '0;
      min_jacobian_r <= bqgf_pkg::MINJ_W'(1);
    end else begin
      if (en) begin
        vld_r <= {vld_r[NL-2:0], in_valid};
      end
      if (cfg_valid) begin
        min_jacobian_r <= cfg_min_jacobian;
      end
    end
  end

  // Determinant rounding and the rejection test against the minimum.
  assign jac_nxt = bqgf_pkg::round_sat16(81'(pja_r) - 81'(pjb_r));
  // Weighted determinant: J*wr*ws is Q.44, brought back to Q16.16.
  assign jw_sum  = 64'(pjw_r) + 64'(28'h8000000);

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r  <= 33'(in_vert1_x) - 33'(in_vert0_x);
      xb_r  <= 33'(in_vert2_x) - 33'(in_vert3_x);
      xc_r  <= 33'(in_vert3_x) - 33'(in_vert0_x);
      xd_r  <= 33'(in_vert2_x) - 33'(in_vert1_x);
      ya_r  <= 33'(in_vert1_y) - 33'(in_vert0_y);
      yb_r  <= 33'(in_vert2_y) - 33'(in_vert3_y);
      yc_r  <= 33'(in_vert3_y) - 33'(in_vert0_y);
      yd_r  <= 33'(in_vert2_y) - 33'(in_vert1_y);
      cms_r <= ONE14 - 18'(in_ref_s);
      cps_r <= ONE14 + 18'(in_ref_s);
      cmr_r <= ONE14 - 18'(in_ref_r);
      cpr_r <= ONE14 + 18'(in_ref_r);
      w1_r  <= 32'(in_weight_r) * 32'(in_weight_s);

      pxa_r <= xa_r * cms_r;
      pxb_r <= xb_r * cps_r;
      pxc_r <= xc_r * cmr_r;
      pxd_r <= xd_r * cpr_r;
      pya_r <= ya_r * cms_r;
      pyb_r <= yb_r * cps_r;
      pyc_r <= yc_r * cmr_r;
      pyd_r <= yd_r * cpr_r;
      w2_r  <= w1_r;

      e3_r.xr <= bqgf_pkg::round_sat16(81'(pxa_r) + 81'(pxb_r));
      e3_r.xs <= bqgf_pkg::round_sat16(81'(pxc_r) + 81'(pxd_r));
      e3_r.yr <= bqgf_pkg::round_sat16(81'(pya_r) + 81'(pyb_r));
      e3_r.ys <= bqgf_pkg::round_sat16(81'(pyc_r) + 81'(pyd_r));
      w3_r    <= w2_r;

      pja_r <= e3_r.xr * e3_r.ys;
      pjb_r <= e3_r.xs * e3_r.yr;
      e4_r  <= e3_r;
      w4_r  <= w3_r;

      jac5_r <= jac_nxt;
      bad5_r <= (jac_nxt < $signed(32'(min_jacobian_r))) || (jac_nxt == '0);
      e5_r   <= e4_r;
      w5_r   <= w4_r;

      // J is positive whenever the item is accepted, so its low 31 bits do.
      pjw_r  <= jac5_r[30:0] * w5_r;
      jac6_r <= jac5_r;
      bad6_r <= bad5_r;
      e6_r   <= e5_r;

      jw7_r  <= (jw_sum[63:28] > 36'(bqgf_pkg::SAT_MAX)) ? bqgf_pkg::SAT_MAX
                                                         : bqgf_pkg::q16_t'(jw_sum[59:28]);
      jac7_r <= jac6_r;
      bad7_r <= bad6_r;
      e7_r   <= e6_r;
    end
  end

  // Divider operands: num*2^17 + J over 2*J gives the rounded num*2^16/J.
  // A negative dividend is complemented so the unsigned divider sees it.
  always_comb begin
    num[0] = 33'(e7_r.ys);
    num[1] = -33'(e7_r.xs);
    num[2] = -33'(e7_r.yr);
    num[3] = 33'(e7_r.xr);
    for (int k = 0; k < 4; k++) begin
      prep[k] = (51'(num[k]) <<< 17) + 51'(jac7_r);
      if (prep[k][bqgf_pkg::DIV_M_W]) begin
        prep[k] = ~prep[k];
        prep[k][bqgf_pkg::DIV_M_W] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        div_m_r[k]   <= prep[k][bqgf_pkg::DIV_M_W-1:0];
        div_d_r[k]   <= {jac7_r, 1'b0};
        div_neg_r[k] <= prep[k][bqgf_pkg::DIV_M_W];
      end
      // Reciprocal: (2^33 + JW) / (2*JW); a zero JW saturates in the divider.
      div_m_r[4]   <= bqgf_pkg::DIV_M_W'(35'h200000000) + bqgf_pkg::DIV_M_W'(jw7_r[30:0]);
      div_d_r[4]   <= {jw7_r, 1'b0};
      div_neg_r[4] <= 1'b0;
      side_r[0]    <= '{jac: jac7_r, jw: jw7_r, bad: bad7_r};
      for (int k = 0; k < DL; k++) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  for (genvar g = 0; g < 5; g++) begin : g_div
    bqgf_div_pipe u_div (
      .clk    (clk),
      .en     (en),
      .m_in   (div_m_r[g]),
      .d_in   (div_d_r[g]),
      .neg_in (div_neg_r[g]),
      .q_out  (div_q[g])
    );
  end

  // Second-order factors: products of the metric, their rounded sums, then
  // JW times each sum split into two partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      prr_a_r <= div_q[0] * div_q[0];
      prr_b_r <= div_q[1] * div_q[1];
      prs_a_r <= div_q[0] * div_q[2];
      prs_b_r <= div_q[1] * div_q[3];
      pss_a_r <= div_q[2] * div_q[2];
      pss_b_r <= div_q[3] * div_q[3];
      m42_r   <= '{rx: div_q[0], ry: div_q[1], sx: div_q[2], sy: div_q[3], inv: div_q[4]};
      s42_r   <= side_r[DL];

      grr_r <= 49'((65'(prr_a_r) + 65'(prr_b_r) + 65'sd32768) >>> 16);
      grs_r <= 49'((65'(prs_a_r) + 65'(prs_b_r) + 65'sd32768) >>> 16);
      gss_r <= 49'((65'(pss_a_r) + 65'(pss_b_r) + 65'sd32768) >>> 16);
      m43_r <= m42_r;
      s43_r <= s42_r;

      hrr_r <= $signed({1'b0, s43_r.jw[30:0]}) * $signed(grr_r[48:24]);
      hrs_r <= $signed({1'b0, s43_r.jw[30:0]}) * $signed(grs_r[48:24]);
      hss_r <= $signed({1'b0, s43_r.jw[30:0]}) * $signed(gss_r[48:24]);
      lrr_r <= s43_r.jw[30:0] * grr_r[23:0];
      lrs_r <= s43_r.jw[30:0] * grs_r[23:0];
      lss_r <= s43_r.jw[30:0] * gss_r[23:0];
      m44_r <= m43_r;
      s44_r <= s43_r;

      // A rejected determinant clears every field but the flag.
      out_bad_r <= s44_r.bad;
      if (s44_r.bad) begin
        out_rx_r  <= '0;
        out_ry_r  <= '0;
        out_sx_r  <= '0;
        out_sy_r  <= '0;
        out_jac_r <= '0;
        out_jw_r  <= '0;
        out_inv_r <= '0;
        out_rr_r  <= '0;
        out_rs_r  <= '0;
        out_ss_r  <= '0;
      end else begin
        out_rx_r  <= m44_r.rx;
        out_ry_r  <= m44_r.ry;
        out_sx_r  <= m44_r.sx;
        out_sy_r  <= m44_r.sy;
        out_jac_r <= s44_r.jac;
        out_jw_r  <= s44_r.jw;
        out_inv_r <= m44_r.inv;
        out_rr_r  <= bqgf_pkg::round_sat16($signed((81'(hrr_r) <<< 24) + 81'(lrr_r)));
        out_rs_r  <= bqgf_pkg::round_sat16($signed((81'(hrs_r) <<< 24) + 81'(lrs_r)));
        out_ss_r  <= bqgf_pkg::round_sat16($signed((81'(hss_r) <<< 24) + 81'(lss_r)));
      end
    end
  end

  assign out_valid             = vld_r[NL-1];
  assign out_metric_rx         = out_rx_r;
  assign out_metric_ry         = out_ry_r;
  assign out_metric_sx         = out_sx_r;
  assign out_metric_sy         = out_sy_r;
  assign out_jacobian          = out_jac_r;
  assign out_weighted_jacobian = out_jw_r;
  assign out_inverse_weighted  = out_inv_r;
  assign out_factor_rr         = out_rr_r;
  assign out_factor_rs         = out_rs_r;
  assign out_factor_ss         = out_ss_r;
  assign out_bad_jacobian      = out_bad_r;

  // A waiting output item stalls the input side.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the output item waits");

  // A rejected item carries only the flag.
  a_bad_zeroes : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_jacobian |-> out_jacobian == '0 && out_weighted_jacobian == '0
      && out_inverse_weighted == '0 && out_factor_rr == '0 && out_metric_rx == '0)
    else $error("rejected item with non-zero fields");

  // The weighted determinant of an accepted item is never negative.
  a_jw_sign : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_jacobian |-> !out_weighted_jacobian[31])
    else $error("negative weighted determinant");

  // A zero weighted determinant gives the largest reciprocal.
  a_inv_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_jacobian && out_weighted_jacobian == '0
      |-> out_inverse_weighted == bqgf_pkg::SAT_MAX)
    else $error("reciprocal of zero not saturated");

endmodule
